// ===== sv/oba_pkg.sv =====
// Package: request/response types and constants of the overlay buffer allocator.
`default_nettype none

package oba_pkg;

    // Request type codes.
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_BYTES   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LINES  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEMORY_LIMIT = 2'd2;
    localparam int CFG_DATA_W = 32;

    // Field widths.
    localparam int PITCH_W = 19;   // row pitch, multiple of 16
    localparam int PROD_W  = 35;   // pitch * height, and the rounded size
    localparam int PAGE_SH = 12;   // 4 KB placement granule
    localparam int PAGE_W  = 21;   // offsets counted in 4 KB pages
    localparam int NEED_W  = 36;   // start + size, exact

    localparam logic [PITCH_W-1:0] PITCH_RND = 19'd15;
    localparam logic [PROD_W-1:0]  SIZE_RND  = 35'd15;
    localparam logic [PROD_W-1:0]  PAGE_RND  = 35'd4095;
    localparam logic [32:0]        BASE_RND  = 33'd4095;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_SLOT = 2'd1,
        ST_NO_MEM  = 2'd2,
        ST_BAD_REL = 2'd3
    } t_status;

    typedef struct packed {
        logic        req_type;
        logic        wide_pixels;
        logic [15:0] buf_width;
        logic [15:0] buf_height;
        logic [1:0]  release_slot;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [1:0]          slot_index;
        logic [31:0]         buf_offset;
        logic [PITCH_W-1:0]  row_pitch;
    } t_rsp;

endpackage

`default_nettype wire

// ===== sv/overlay_buffer_allocator.sv =====
// Overlay buffer allocator: slot table, placement and limit check in one pass.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries allocate and
//   release requests; output channel (o_out_valid / i_out_ready / o_out_data)
//   returns exactly one response per request, in request order.
//   The config port (i_cfg_we / i_cfg_index / i_cfg_data) writes line_bytes,
//   frame_lines and memory_limit; write it only while no request is in flight.
//   Unknown indexes are ignored.
// Timing:
//   A request is multiplied out (pitch * height) on transfer and registered
//   into the work stage, then resolved there: slot pick, placement and the
//   table update all happen at the edge that loads the response register.
//   A request passes the work stage and then the response register before
//   o_out_valid; one request per cycle is sustained while i_out_ready stays
//   high, set by the single work stage that reads and writes the slot table.
// Reset:
//   Clears the config registers, marks every slot free and empties both
//   stages. The end offsets in the slot table are not cleared.
// Stall:
//   When the receiver holds i_out_ready low, the response register holds, the
//   work stage holds behind it and o_in_ready drops once both are full.
`default_nettype none

module overlay_buffer_allocator import oba_pkg::*; #(
    parameter int SLOT_COUNT = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire t_req                   i_in_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output t_rsp                        o_out_data
);

    localparam int SW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int LEVELS = $clog2(SLOT_COUNT);
    localparam int LEAVES = 1 << LEVELS;

    // Work stage contents: request type, release slot, pitch and pitch * height.
    typedef struct packed {
        logic               req_type;
        logic [1:0]         release_slot;
        logic [PITCH_W-1:0] pitch;
        logic [PROD_W-1:0]  prod;
    } t_work;

    // Configuration registers.
    logic [15:0] r_line_bytes;
    logic [15:0] r_frame_lines;
    logic [31:0] r_memory_limit;
    logic [PAGE_W-1:0] r_base_k;       // frame buffer end, in 4 KB pages

    // Slot table: used flags and end offsets rounded up to 4 KB pages.
    logic [SLOT_COUNT-1:0] r_used;
    logic [SLOT_COUNT-1:0] n_used;
    logic [PAGE_W-1:0]     r_end_k [SLOT_COUNT];

    // Pipeline registers.
    logic  r_work_valid;
    t_work r_work;
    t_work n_work;
    logic  r_out_valid;
    t_rsp  r_out;
    t_rsp  n_out;

    logic  work_adv;
    logic  in_xfer;

    // Stage 0 datapath.
    logic [17:0]        pix_bytes;
    logic [PITCH_W-1:0] pitch_sum;

    // Stage 1 datapath.
    logic [PAGE_W-1:0]  tree [LEVELS+1][LEAVES];
    logic [PAGE_W-1:0]  used_max_k;
    logic [PAGE_W-1:0]  start_k;
    logic [32:0]        start;
    logic [PROD_W-1:0]  size_sum;
    logic [PROD_W-1:0]  size;
    logic [PROD_W-1:0]  prod_pg_sum;
    logic [PROD_W-PAGE_SH-1:0] prod_k;
    logic [PROD_W-PAGE_SH-1:0] end_k_sum;
    logic [NEED_W-1:0]  need;
    logic               no_mem;
    logic [SW-1:0]      free_idx;
    logic               any_free;
    logic [4:0]         free_ext;
    logic [4:0]         rel_ext;
    logic [SW-1:0]      rel_idx;
    logic               rel_ok;
    logic               write_end;
    logic [31:0]        base_prod;
    logic [32:0]        base_sum;

    assign work_adv   = r_work_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_work_valid || work_adv;
    assign in_xfer    = i_in_valid && o_in_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration writes; the frame buffer end is kept in pages.
    assign base_prod = r_line_bytes * r_frame_lines;
    assign base_sum  = {1'b0, base_prod} + BASE_RND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bytes   <= '0;
            r_frame_lines  <= '0;
            r_memory_limit <= '0;
            r_base_k       <= '0;
        end else begin
            r_base_k <= base_sum[32:PAGE_SH];
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LINE_BYTES:   r_line_bytes   <= i_cfg_data[15:0];
                    CFG_FRAME_LINES:  r_frame_lines  <= i_cfg_data[15:0];
                    CFG_MEMORY_LIMIT: r_memory_limit <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Stage 0: pitch rounded to 16 bytes, then the raw buffer bytes.
    always_comb begin
        pix_bytes = i_in_data.wide_pixels ? {i_in_data.buf_width, 2'b00}
                                          : {1'b0, i_in_data.buf_width, 1'b0};
        pitch_sum            = {1'b0, pix_bytes} + PITCH_RND;
        n_work.req_type      = i_in_data.req_type;
        n_work.release_slot  = i_in_data.release_slot;
        n_work.pitch         = pitch_sum & ~PITCH_RND;
        n_work.prod          = n_work.pitch * i_in_data.buf_height;
    end

    // Highest used end page, through a balanced max tree.
    always_comb begin
        for (int l = 0; l <= LEVELS; l++) begin
            for (int j = 0; j < LEAVES; j++) begin
                tree[l][j] = '0;
            end
        end
        for (int j = 0; j < SLOT_COUNT; j++) begin
            tree[0][j] = r_used[j] ? r_end_k[j] : '0;
        end
        for (int l = 0; l < LEVELS; l++) begin
            for (int j = 0; j < (LEAVES >> (l + 1)); j++) begin
                tree[l+1][j] = (tree[l][2*j] > tree[l][2*j+1]) ? tree[l][2*j]
                                                               : tree[l][2*j+1];
            end
        end
        used_max_k = tree[LEVELS][0];
    end

    // Lowest free slot.
    always_comb begin
        free_idx = '0;
        any_free = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_idx = SW'(i);
                any_free = 1'b1;
            end
        end
    end

    // Stage 1: placement, limit check, release, table update.
    always_comb begin
        start_k     = (used_max_k > r_base_k) ? used_max_k : r_base_k;
        start       = {start_k, {PAGE_SH{1'b0}}};
        size_sum    = r_work.prod + SIZE_RND;
        size        = size_sum & ~SIZE_RND;
        prod_pg_sum = r_work.prod + PAGE_RND;
        prod_k      = prod_pg_sum[PROD_W-1:PAGE_SH];
        end_k_sum   = {{(PROD_W-PAGE_SH-PAGE_W){1'b0}}, start_k} + prod_k;
        need        = {{(NEED_W-33){1'b0}}, start} + {{(NEED_W-PROD_W){1'b0}}, size};
        no_mem      = need > {{(NEED_W-32){1'b0}}, r_memory_limit};
        free_ext    = 5'(free_idx);
        rel_ext     = {3'b000, r_work.release_slot};
        rel_idx     = rel_ext[SW-1:0];
        rel_ok      = (rel_ext < 5'(SLOT_COUNT)) && r_used[rel_idx];

        n_used            = r_used;
        write_end         = 1'b0;
        n_out.status      = ST_OK;
        n_out.slot_index  = '0;
        n_out.buf_offset  = '0;
        n_out.row_pitch   = '0;

        if (r_work.req_type == REQ_RELEASE) begin
            if (rel_ok) begin
                n_used[rel_idx] = 1'b0;
            end else begin
                n_out.status = ST_BAD_REL;
            end
        end else if (!any_free) begin
            n_out.status = ST_NO_SLOT;
        end else if (no_mem) begin
            n_out.status = ST_NO_MEM;
        end else begin
            n_used[free_idx]    = 1'b1;
            write_end           = 1'b1;
            n_out.slot_index    = free_ext[1:0];
            n_out.buf_offset    = start[31:0];
            n_out.row_pitch     = r_work.pitch;
        end
    end

    // Control state: stage valids and used flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_used       <= '0;
        end else begin
            if (in_xfer) begin
                r_work_valid <= 1'b1;
            end else if (work_adv) begin
                r_work_valid <= 1'b0;
            end
            if (work_adv) begin
                r_out_valid <= 1'b1;
                r_used      <= n_used;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers and slot end table.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_work <= n_work;
        end
        if (work_adv) begin
            r_out <= n_out;
            if (write_end) begin
                r_end_k[free_idx] <= end_k_sum[PAGE_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// ===== test/tb_overlay_buffer_allocator.sv =====
// Testbench: directed and random allocate/release traffic against a slot-table predictor.
module tb_overlay_buffer_allocator;
    import oba_pkg::*;

    localparam int SLOT_COUNT      = 4;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int DRAIN_CYCLES    = 4;       // margin after every response is back
    localparam int CYCLE_LIMIT     = 200000;
    localparam int MAX_REPORTS     = 20;

    // Index that maps to no register; writes to it must be ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // One line of the directed table: either a register write or a request,
    // with the response spelled out where it is obvious.
    typedef struct {
        bit                     is_cfg;
        logic [CFG_INDEX_W-1:0] cfg_index;
        logic [CFG_DATA_W-1:0]  cfg_value;
        t_req                   req;
        bit                     typed;
        t_rsp                   rsp;
    } t_stim_row;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_in_valid  = 1'b0;
    t_req                   i_in_data   = '0;
    logic                   i_out_ready = 1'b1;
    logic                   o_in_ready;
    logic                   o_out_valid;
    t_rsp                   o_out_data;

    // Local copy of the allocator: registers and slot table.
    logic [15:0] cfg_line_bytes   = '0;
    logic [15:0] cfg_frame_lines  = '0;
    logic [31:0] cfg_memory_limit = '0;
    bit          slot_used [SLOT_COUNT];
    logic [31:0] slot_end  [SLOT_COUNT];

    t_rsp        expected_rsps[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    overlay_buffer_allocator #(
        .SLOT_COUNT (SLOT_COUNT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bound the run; a hung handshake ends here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic longint unsigned align_up(longint unsigned v, longint unsigned mask);
        return (v + mask) & ~mask;
    endfunction

    // Predict the response to one request and advance the local slot table.
    function automatic t_rsp resolve_request(t_req r);
        t_rsp            rsp;
        longint unsigned bpp;
        longint unsigned pitch;
        longint unsigned size;
        longint unsigned start;
        int              slot;
        rsp  = '0;
        slot = -1;
        if (r.req_type == REQ_RELEASE) begin
            if (int'(r.release_slot) < SLOT_COUNT && slot_used[r.release_slot])
                slot_used[r.release_slot] = 1'b0;
            else
                rsp.status = ST_BAD_REL;
            return rsp;
        end
        bpp   = r.wide_pixels ? 64'd4 : 64'd2;
        pitch = align_up(64'(r.buf_width) * bpp, 64'd15);
        size  = align_up(pitch * 64'(r.buf_height), 64'd15);
        start = align_up(64'(cfg_line_bytes) * 64'(cfg_frame_lines), 64'd4095);
        // Lowest free slot wins.
        for (int i = 0; i < SLOT_COUNT; i++)
            if (slot < 0 && !slot_used[i])
                slot = i;
        if (slot < 0) begin
            rsp.status = ST_NO_SLOT;
            return rsp;
        end
        // Push the start past every live buffer that reaches beyond it.
        for (int i = 0; i < SLOT_COUNT; i++)
            if (slot_used[i] && 64'(slot_end[i]) > start)
                start = align_up(64'(slot_end[i]), 64'd4095);
        // Exact sum: a carry past 32 bits is simply out of memory.
        if (start + size > 64'(cfg_memory_limit)) begin
            rsp.status = ST_NO_MEM;
            return rsp;
        end
        slot_used[slot]   = 1'b1;
        slot_end[slot]    = 32'(start + pitch * 64'(r.buf_height));
        rsp.status        = ST_OK;
        rsp.slot_index    = 2'(slot);
        rsp.buf_offset    = 32'(start);
        rsp.row_pitch     = PITCH_W'(pitch);
        return rsp;
    endfunction

    // Mostly small buffers so allocations fit, with full-range and edge values mixed in.
    function automatic logic [15:0] random_dim(int small_max);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            return 16'($urandom_range(0, small_max));
        if (pick < 95)
            return 16'($urandom_range(0, 65535));
        return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    endfunction

    // Releases mostly target a live slot so the table keeps turning over.
    function automatic t_req random_request();
        t_req r;
        int   live_slots[$];
        r.req_type     = ($urandom_range(0, 99) < 55) ? REQ_ALLOC : REQ_RELEASE;
        r.wide_pixels  = 1'($urandom_range(0, 1));
        r.buf_width    = random_dim(255);
        r.buf_height   = random_dim(63);
        r.release_slot = 2'($urandom_range(0, 3));
        if (r.req_type == REQ_RELEASE && $urandom_range(0, 99) < 80) begin
            for (int i = 0; i < SLOT_COUNT; i++)
                if (slot_used[i])
                    live_slots.push_back(i);
            if (live_slots.size() > 0)
                r.release_slot = 2'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
        end
        return r;
    endfunction

    function automatic int idle_gap();
        int g;
        g = 0;
        while (g < 16 && $urandom_range(0, 99) < send_idle_pct)
            g++;
        return g;
    endfunction

    // Present one request, hold it until the transfer, then log the expected response.
    task automatic send_request(t_req r, t_rsp typed_rsp, bit use_typed);
        int   gap;
        t_rsp predicted;
        gap = idle_gap();
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = resolve_request(r);
        expected_rsps.push_back(use_typed ? typed_rsp : predicted);
    endtask

    // Drop valid and wait until every response is back and the pipe is quiet.
    task automatic wait_drained();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_LINE_BYTES:   cfg_line_bytes   = value[15:0];
            CFG_FRAME_LINES:  cfg_frame_lines  = value[15:0];
            CFG_MEMORY_LIMIT: cfg_memory_limit = value;
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        @(negedge i_clk) i_cfg_we <= 1'b0;
    endtask

    // New register set for a random phase; the first two phases pin the extremes.
    task automatic phase_config(int phase);
        logic [15:0]     lb;
        logic [15:0]     fl;
        longint unsigned base;
        longint unsigned lim;
        if (phase == 0) begin
            lb  = 16'h0000;
            fl  = 16'h0000;
            lim = 64'hFFFF_FFFF;
        end else if (phase == 1) begin
            lb  = 16'hFFFF;
            fl  = 16'hFFFF;
            lim = 64'hFFFF_FFFF;
        end else begin
            lb   = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4096));
            fl   = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 1024));
            base = align_up(64'(lb) * 64'(fl), 64'd4095);
            lim  = base + 64'($urandom_range(4096, 1 << 20));
            if ($urandom_range(0, 4) == 0)
                lim = 64'($urandom());
            if (lim > 64'hFFFF_FFFF)
                lim = 64'hFFFF_FFFF;
        end
        wait_drained();
        cfg_write(CFG_LINE_BYTES, 32'(lb));
        cfg_write(CFG_FRAME_LINES, 32'(fl));
        cfg_write(CFG_MEMORY_LIMIT, 32'(lim));
        cfg_close();
    endtask

    function automatic t_stim_row alloc_row(logic wide, logic [15:0] w, logic [15:0] h);
        t_stim_row row;
        row                 = '{default: '0};
        row.req.req_type    = REQ_ALLOC;
        row.req.wide_pixels = wide;
        row.req.buf_width   = w;
        row.req.buf_height  = h;
        return row;
    endfunction

    function automatic t_stim_row release_row(logic [1:0] s);
        t_stim_row row;
        row                  = '{default: '0};
        row.req.req_type     = REQ_RELEASE;
        row.req.release_slot = s;
        return row;
    endfunction

    function automatic t_stim_row cfg_row(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        t_stim_row row;
        row           = '{default: '0};
        row.is_cfg    = 1'b1;
        row.cfg_index = idx;
        row.cfg_value = v;
        return row;
    endfunction

    function automatic t_stim_row known(t_stim_row row, t_status st, logic [1:0] slot,
                                        logic [31:0] offs, logic [PITCH_W-1:0] pitch);
        row.typed          = 1'b1;
        row.rsp.status     = st;
        row.rsp.slot_index = slot;
        row.rsp.buf_offset = offs;
        row.rsp.row_pitch  = pitch;
        return row;
    endfunction

    // Receiver: stall at random per the current phase.
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Compare each response transfer, field by field, against the oldest expectation.
    always @(posedge i_clk) begin : check_rsp
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("response with nothing outstanding");
            end else begin
                want = expected_rsps.pop_front();
                if (o_out_data.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_out_data.status, want.status));
                if (o_out_data.slot_index !== want.slot_index)
                    report_mismatch($sformatf("slot_index got %0d want %0d",
                                              o_out_data.slot_index, want.slot_index));
                if (o_out_data.buf_offset !== want.buf_offset)
                    report_mismatch($sformatf("buf_offset got %h want %h",
                                              o_out_data.buf_offset, want.buf_offset));
                if (o_out_data.row_pitch !== want.row_pitch)
                    report_mismatch($sformatf("row_pitch got %0d want %0d",
                                              o_out_data.row_pitch, want.row_pitch));
            end
        end
    end

    initial begin
        t_stim_row  directed_rows[$];
        t_idle_mode mode;

        // Registers reset to zero, so the limit is zero until written.
        directed_rows.push_back(known(alloc_row(1'b0, 16'd0, 16'd0), ST_OK, 2'd0, 32'd0, '0));
        directed_rows.push_back(known(release_row(2'd1), ST_BAD_REL, 2'd0, 32'd0, '0));
        directed_rows.push_back(known(release_row(2'd0), ST_OK, 2'd0, 32'd0, '0));
        directed_rows.push_back(known(alloc_row(1'b1, 16'd1, 16'd1), ST_NO_MEM, 2'd0, 32'd0, '0));
        directed_rows.push_back(cfg_row(CFG_UNUSED, 32'hFFFF_FFFF));
        // Widest narrow-pixel row with zero height takes no space.
        directed_rows.push_back(known(alloc_row(1'b0, 16'hFFFF, 16'd0), ST_OK, 2'd0, 32'd0,
                                      PITCH_W'(131072)));
        // Largest frame buffer: base rounds up to the 4 KB page boundary 0xFFFE1000.
        directed_rows.push_back(cfg_row(CFG_LINE_BYTES, 32'h0000_FFFF));
        directed_rows.push_back(cfg_row(CFG_FRAME_LINES, 32'h0000_FFFF));
        directed_rows.push_back(cfg_row(CFG_MEMORY_LIMIT, 32'hFFFF_FFFF));
        directed_rows.push_back(known(alloc_row(1'b1, 16'hFFFF, 16'hFFFF), ST_NO_MEM,
                                      2'd0, 32'd0, '0));
        directed_rows.push_back(known(alloc_row(1'b0, 16'd0, 16'd0), ST_OK, 2'd1,
                                      32'hFFFE_1000, '0));
        // Sum crosses 2^32: must be out of memory, not a wrapped fit.
        directed_rows.push_back(known(alloc_row(1'b1, 16'hFFFF, 16'd1), ST_NO_MEM,
                                      2'd0, 32'd0, '0));
        directed_rows.push_back(alloc_row(1'b0, 16'd8, 16'd1));
        directed_rows.push_back(alloc_row(1'b0, 16'd0, 16'd0));
        directed_rows.push_back(known(alloc_row(1'b0, 16'd1, 16'd1), ST_NO_SLOT,
                                      2'd0, 32'd0, '0));
        directed_rows.push_back(known(release_row(2'd3), ST_OK, 2'd0, 32'd0, '0));
        directed_rows.push_back(known(release_row(2'd3), ST_BAD_REL, 2'd0, 32'd0, '0));
        directed_rows.push_back(cfg_row(CFG_MEMORY_LIMIT, 32'h0000_0000));
        directed_rows.push_back(alloc_row(1'b0, 16'd0, 16'd0));
        directed_rows.push_back(known(release_row(2'd0), ST_OK, 2'd0, 32'd0, '0));
        directed_rows.push_back(known(release_row(2'd1), ST_OK, 2'd0, 32'd0, '0));
        directed_rows.push_back(known(release_row(2'd2), ST_OK, 2'd0, 32'd0, '0));
        directed_rows.push_back(cfg_row(CFG_LINE_BYTES, 32'h0000_0000));
        directed_rows.push_back(known(alloc_row(1'b0, 16'd0, 16'd0), ST_OK, 2'd0, 32'd0, '0));
        directed_rows.push_back(known(alloc_row(1'b1, 16'hFFFF, 16'hFFFF), ST_NO_MEM,
                                      2'd0, 32'd0, '0));

        // Hold reset, then release it at a falling edge.
        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed table; register writes only once the pipe is empty.
        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_cfg) begin
                wait_drained();
                cfg_write(directed_rows[k].cfg_index, directed_rows[k].cfg_value);
                cfg_close();
            end else begin
                send_request(directed_rows[k].req, directed_rows[k].rsp, directed_rows[k].typed);
            end
        end

        // Random phases, cycling through the idle patterns with a fresh register set each.
        for (int phase = 0; phase < PHASES; phase++) begin
            mode = t_idle_mode'(phase % 4);
            case (mode)
                IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                IDLE_SENDER:   begin send_idle_pct = 51; recv_stall_pct = 0;  end
                IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default:       begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            phase_config(phase);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Now and then hold off until every response is back.
                if ((phase == 0 && n == ITEMS_PER_PHASE / 2) || $urandom_range(0, 79) == 0)
                    wait_drained();
                send_request(random_request(), '0, 1'b0);
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== overlay_buffer_allocator.f =====
sv/oba_pkg.sv
sv/overlay_buffer_allocator.sv
test/tb_overlay_buffer_allocator.sv
